### design/d2h_pkg.sv
// ----------------------------------------------------------------------------
// d2h_pkg
// Shared types and constants for the double to half converter.
// ----------------------------------------------------------------------------
package d2h_pkg;

   localparam logic [15:0] HALF_POS_INF = 16'h7c00;
   localparam logic [15:0] HALF_NEG_INF = 16'hfc00;
   localparam logic [15:0] HALF_NAN     = 16'h7c80;
   localparam logic [10:0] EXP_BIAS_GAP = 11'd896;  // 1023 - 127
   localparam logic [7:0]  REBIAS       = 8'h70;

   // Result class decided in the first stage
   typedef enum logic [1:0] {
      CLS_NORMAL = 2'd0,
      CLS_FIXED  = 2'd1
   } class_type;

   // Stage 1 -> stage 2 payload
   typedef struct packed {
      class_type   cls;
      logic [15:0] fixed_val;
      logic        sign;
      logic [7:0]  e32;
      logic [22:0] m32;
      logic        round_up;
   } s1_type;

   // Stage 2 -> stage 3 payload
   typedef struct packed {
      class_type   cls;
      logic [15:0] fixed_val;
      logic        sign;
      logic [7:0]  e32;
      logic [22:0] m32;
   } s2_type;

endpackage

### design/d2h_classify.sv
// ----------------------------------------------------------------------------
// d2h_classify
// Sorts a binary64 pattern into special results or a value to be rounded.
// ----------------------------------------------------------------------------
module d2h_classify
   import d2h_pkg::*;
(
   input  logic [63:0] double_bits,
   output s1_type      s1
);

   logic        sgn;
   logic [10:0] e64;
   logic [51:0] frac;
   logic        is_nan;
   logic        is_big;
   logic        is_tiny;
   logic [28:0] rem;
   logic [22:0] m;

   assign sgn  = double_bits[63];
   assign e64  = double_bits[62:52];
   assign frac = double_bits[51:0];
   assign m    = frac[51:29];
   assign rem  = frac[28:0];

   // 65504 = 1.1111111111b * 2^15: above it if exp > 15, or exp 15 with more bits
   assign is_nan = (e64 == 11'h7ff) && (frac != 52'd0);
   assign is_big = (e64 > 11'd1038) ||
                   ((e64 == 11'd1038) && (frac > {10'h3ff, 42'd0}));
   // 0.000000059604645 lies just above 2^-24: exp 999, frac 0x102f4fd
   assign is_tiny = (e64 < 11'd999) ||
                    ((e64 == 11'd999) && (frac < 52'h000000102f4fd));

   always_comb begin
      s1.sign      = sgn;
      s1.m32       = m;
      s1.e32       = (e64 >= EXP_BIAS_GAP) ? 8'(e64 - EXP_BIAS_GAP) : 8'd0;
      s1.round_up  = (rem > 29'h1000_0000) || ((rem == 29'h1000_0000) && m[0]);
      s1.cls       = CLS_FIXED;
      s1.fixed_val = 16'h0000;
      priority if (is_nan) begin
         s1.fixed_val = HALF_NAN;
      end else if (is_big) begin
         s1.fixed_val = sgn ? HALF_NEG_INF : HALF_POS_INF;
      end else if (is_tiny) begin
         s1.fixed_val = 16'h0000;
      end else begin
         s1.cls = CLS_NORMAL;
      end
   end

endmodule

### design/double_to_half_convert_core.sv
// ----------------------------------------------------------------------------
// double_to_half_convert_core
// Streams binary64 patterns in, binary16 patterns out, three register stages.
// ----------------------------------------------------------------------------
// channel | direction | tdata fields (low bit up)
// req     | in        | double_bits[63:0]
// rsp     | out       | half_bits[15:0]
//
// One request per cycle while rsp is not stalled; the result passes through three
// register stages (stage 1, stage 2, stage 3) before it is offered on rsp.
// Stage 1 classifies and decides rounding, stage 2 rounds to single,
// stage 3 passes fixed results, rebiases or shifts into the half subnormal range.
// Synchronous reset clears the stage valid bits only.
// A stall on rsp freezes a stage holding data only when every later stage holds data; bubbles are filled.
module double_to_half_convert_core
   import d2h_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // double_bits[63:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // half_bits[15:0]
);

   s1_type      s1_in, s1_ff;
   s2_type      s2_in, s2_ff;
   logic [15:0] s3_in, s3_ff;
   logic        v1_ff, v2_ff, v3_ff;
   logic        en1, en2, en3;
   logic [23:0] m_rnd;
   logic [7:0]  shift;
   logic [23:0] sig;

   // Stall chain: a stage moves when the next one can take its item
   assign en3 = !v3_ff || rsp_tready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   d2h_classify u_classify (
      .double_bits (req_tdata),
      .s1          (s1_in)
   );

   // Stage 2: round to single precision
   always_comb begin
      m_rnd           = {1'b0, s1_ff.m32} + 24'(s1_ff.round_up);
      s2_in.cls       = s1_ff.cls;
      s2_in.fixed_val = s1_ff.fixed_val;
      s2_in.sign      = s1_ff.sign;
      s2_in.m32       = m_rnd[22:0];
      s2_in.e32       = m_rnd[23] ? s1_ff.e32 + 8'd1 : s1_ff.e32;
   end

   // Stage 3: rebias, or shift into the subnormal range
   always_comb begin
      sig   = {1'b1, s2_ff.m32};
      shift = 8'd126 - s2_ff.e32;
      unique case (s2_ff.cls)
         CLS_FIXED:  s3_in = s2_ff.fixed_val;
         CLS_NORMAL: begin
            if (s2_ff.e32 > REBIAS) begin
               s3_in = {s2_ff.sign, 5'(s2_ff.e32 - REBIAS), s2_ff.m32[22:13]};
            end else if (shift < 8'd32) begin
               s3_in = {s2_ff.sign, 5'd0, 10'(sig >> shift[4:0])};
            end else begin
               s3_in = {s2_ff.sign, 15'd0};
            end
         end
         default:    s3_in = s2_ff.fixed_val;
      endcase
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = s3_ff;

endmodule

### test/tb_double_to_half_convert_core.sv
// ----------------------------------------------------------------------------
// tb_double_to_half_convert_core
// Streams binary64 patterns through the converter and compares every binary16
// response with a local predictor, under random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
module tb_double_to_half_convert_core;
   import d2h_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 2000;
   localparam int DRAIN_CYCLES = 10;

   // Predict the half pattern for one double pattern
   function automatic logic [15:0] half_of_double(logic [63:0] bits);
      real         x, ax;
      logic        sgn;
      logic [10:0] e64;
      logic [31:0] e, shift;
      logic [51:0] frac;
      logic [23:0] m;
      logic [28:0] rem;
      logic [4:0]  expf;
      logic [9:0]  mant;
      logic [31:0] sig;
      e64 = bits[62:52];
      frac = bits[51:0];
      if (e64 == 11'h7ff && frac != 52'd0) return HALF_NAN;
      if (e64 == 11'h7ff) return bits[63] ? HALF_NEG_INF : HALF_POS_INF;
      x = $bitstoreal(bits);
      if (x > 65504.0) return HALF_POS_INF;
      if (x < -65504.0) return HALF_NEG_INF;
      ax = (x < 0.0) ? -x : x;
      if (ax < 0.000000059604645) return 16'h0000;
      sgn = bits[63];
      e = (e64 >= 11'd896) ? 32'(e64) - 32'd896 : 32'd0;
      m = {1'b0, frac[51:29]};
      rem = frac[28:0];
      if (rem > 29'h10000000 || (rem == 29'h10000000 && m[0])) m = m + 24'd1;
      if (m == 24'h800000) begin
         m = 24'd0;
         e = e + 32'd1;
      end
      e = e & 32'hff;
      if (e > 32'h70) begin
         expf = 5'(e - 32'h70);
         mant = m[22:13];
      end else begin
         expf = 5'd0;
         shift = 32'd126 - e;
         sig = {9'd0, 1'b1, m[22:0]};
         mant = (shift < 32'd32) ? 10'(sig >> shift) : 10'd0;
      end
      return {sgn, expf, mant};
   endfunction

   // Scoreboard of pending half results
   class half_scoreboard;
      logic [15:0] pending_halves[$];
      int          mismatches;

      function void note_request(logic [63:0] bits);
         pending_halves.push_back(half_of_double(bits));
      endfunction

      function void check_response(logic [15:0] got);
         logic [15:0] want;
         if (pending_halves.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         want = pending_halves.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("half_bits mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        long_hold = 0;
   bit          sending_done = 0;
   half_scoreboard board = new();

   double_to_half_convert_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   // Monitor both channels at the edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end

   // Receiver stall pattern; one long hold-off early in the random part
   initial begin : receiver
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (long_hold) rsp_tready <= 1'b0;
         else if ((phase / 64) % 3 == 0) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin : hold_off
      wait (!reset);
      repeat (200) @(posedge clock);
      long_hold = 1;
      repeat (150) @(posedge clock);
      long_hold = 0;
   end

   // Offer one request and wait for it to be taken
   task automatic send_request(logic [63:0] bits);
      req_tvalid <= 1'b1;
      req_tdata <= bits;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Random double focused on the interesting exponent bands
   function automatic logic [63:0] random_double();
      logic [63:0] v;
      logic [10:0] e;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: e = 11'h7ff;
         1: e = 11'($urandom_range(0, 2047));
         2: e = 11'($urandom_range(0, 2));
         3: e = 11'($urandom_range(1000, 1060));
         4: e = 11'($urandom_range(868, 900));
         5: begin
            e = 11'($urandom_range(1037, 1038));
            v[51:29] = '1;
         end
         default: e = 11'($urandom_range(995, 1040));
      endcase
      v[62:52] = e;
      if ($urandom_range(0, 7) == 0) v[28:0] = 29'h10000000;
      return v;
   endfunction

   initial begin : stimulus
      logic [63:0] directed[$];
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
                   64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0000,
                   64'hffff_ffff_ffff_ffff, 64'h7ff0_0000_0000_0001,
                   64'h40ef_fc00_0000_0000, 64'hc0ef_fc00_0000_0000,
                   64'h40ef_fc00_0000_0001, 64'h40ef_fe00_0000_0000,
                   64'h3e70_0000_0000_0000, 64'h3e6f_ffff_ffff_ffff,
                   64'hbe70_0000_0000_0000, 64'h0000_0000_0000_0001,
                   64'h3f10_0000_0000_0000, 64'h3f0f_ffff_ffff_ffff,
                   64'h3ff0_0000_1000_0000, 64'h3ff0_0000_3000_0000,
                   64'h3fef_ffff_f000_0000, 64'h3ff0_0000_1000_0001,
                   64'h3ff5_5555_5555_5555, 64'hbff0_0000_0000_0000,
                   64'h7fef_ffff_ffff_ffff, 64'h5555_5555_5555_5555,
                   64'h3e70_0000_0102_f4fc, 64'h3e70_0000_0102_f4fd};
      foreach (directed[i]) send_request(directed[i]);
      n = 0;
      while (n < N_RANDOM) begin
         int burst;
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
            send_request(random_double());
         idle_gap($urandom_range(0, 1) ? $urandom_range(1, 12) : 0);
      end
      req_tvalid <= 1'b0;
      sending_done = 1;
   end

   // Drain and report
   initial begin : finisher
      wait (sending_done);
      while (board.pending_halves.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending_halves.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
